FILE: rtl/core/ddsp_pkg.sv
package ddsp_pkg;

  // field widths
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SPEED_W   = 24;
  localparam int unsigned PWM_W     = 10;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned INTEG_W   = 32;
  localparam int unsigned DELTA_W   = 33;
  localparam int unsigned DRIVE_W   = 31;

  // pipeline slots from input register to output register
  localparam int unsigned PIPE_SLOTS = 7;

  // parameter defaults
  localparam int unsigned MAX_PWM_DEF        = 999;
  localparam int unsigned SENSOR_DIVISOR_DEF = 200;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP_W   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_FORWARD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_FORWARD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_ROTATE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_ROTATE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_MODE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN     = 3'd7;

  // register reset values
  localparam logic [CFG_W-1:0] RST_RAMP_STEP_X = 16'd2980;
  localparam logic [CFG_W-1:0] RST_RAMP_STEP_W = 16'd5714;
  localparam logic [CFG_W-1:0] RST_KP_FORWARD  = 16'd512;
  localparam logic [CFG_W-1:0] RST_KD_FORWARD  = 16'd1024;
  localparam logic [CFG_W-1:0] RST_KP_ROTATE   = 16'd256;
  localparam logic [CFG_W-1:0] RST_KD_ROTATE   = 16'd5120;
  localparam logic [CFG_W-1:0] RST_GYRO_GAIN   = 16'd17712;

  // rotational feedback source
  localparam logic [1:0] FB_MODE_GYRO_ENC = 2'd0;
  localparam logic [1:0] FB_MODE_GYRO     = 2'd1;
  localparam logic [1:0] FB_MODE_ENC      = 2'd2;

  // load strobes for the pd law stages
  typedef struct packed {
    logic prod_ld;
    logic drive_ld;
  } pd_en_t;

endpackage

FILE: rtl/core/ddsp_in_if.sv
interface ddsp_in_if import ddsp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [COUNT_W-1:0]         left_count;
  logic [COUNT_W-1:0]         right_count;
  logic signed [SAMPLE_W-1:0] gyro_rate;
  logic signed [SAMPLE_W-1:0] side_error;
  logic                       use_side_error;
  logic signed [SPEED_W-1:0]  target_forward;
  logic signed [SPEED_W-1:0]  target_rotate;

  modport source (
    output valid, left_count, right_count, gyro_rate, side_error, use_side_error,
    output target_forward, target_rotate,
    input  ready
  );

  modport sink (
    input  valid, left_count, right_count, gyro_rate, side_error, use_side_error,
    input  target_forward, target_rotate,
    output ready
  );
endinterface

FILE: rtl/core/ddsp_out_if.sv
interface ddsp_out_if import ddsp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [PWM_W-1:0]           left_pwm_fwd;
  logic [PWM_W-1:0]           left_pwm_rev;
  logic [PWM_W-1:0]           right_pwm_fwd;
  logic [PWM_W-1:0]           right_pwm_rev;
  logic signed [COUNT_W-1:0]  forward_change;
  logic signed [SPEED_W-1:0]  speed_forward_now;

  modport source (
    output valid, left_pwm_fwd, left_pwm_rev, right_pwm_fwd, right_pwm_rev,
    output forward_change, speed_forward_now,
    input  ready
  );

  modport sink (
    input  valid, left_pwm_fwd, left_pwm_rev, right_pwm_fwd, right_pwm_rev,
    input  forward_change, speed_forward_now,
    output ready
  );
endinterface

FILE: rtl/core/diff_drive_speed_pd_loop_unit.sv
// differential-drive pd speed loop, one control tick per input beat
//
// in_ch carries one tick: two raw encoder counters, gyro rate, wall sensor
// error with its enable, and target forward / rotational speeds (q12.12).
// out_ch returns one beat per tick: four direction pwm duties (right side
// inverted), the averaged encoder change and the ramped forward speed.
// cfg_we/cfg_index/cfg_wdata write the eight tuning registers; write them
// only while no tick is in flight.
//
// throughput: one beat per cycle while out_ch is ready. in_ch to out_ch is
// the seven-slot pipeline (input register, feedback terms, integrator
// update, gain multiply, scale, mix, output register). loop state (previous
// counters, ramped speeds, integrators) updates once per tick as the beat
// leaves its stage, so ticks follow back to back.
//
// reset (synchronous, rst_n low) empties the pipeline, zeroes the loop state
// and loads the register defaults. when out_ch stalls, beats pile up into
// empty slots behind it; in_ch.ready drops only once every slot is full.
module diff_drive_speed_pd_loop_unit import ddsp_pkg::*; #(
  parameter int unsigned MAX_PWM        = MAX_PWM_DEF,
  parameter int unsigned SENSOR_DIVISOR = SENSOR_DIVISOR_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ddsp_in_if.sink              in_ch,
  ddsp_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // exact floor(m / SENSOR_DIVISOR) for m < 2^16 as (m * recip) >> 32
  localparam longint unsigned RECIP_L =
    ((64'd1 << 32) + 64'(SENSOR_DIVISOR) - 64'd1) / 64'(SENSOR_DIVISOR);
  localparam logic [32:0] SIDE_RECIP = 33'(RECIP_L);
  localparam logic signed [31:0] PWM_HI = 32'(MAX_PWM);
  localparam logic signed [31:0] PWM_LO = -PWM_HI;

  // ---------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------

  // step toward target, landing on it instead of passing it
  function automatic logic signed [SPEED_W-1:0] ramp_f(
    input logic signed [SPEED_W-1:0] cur,
    input logic signed [SPEED_W-1:0] tgt,
    input logic [CFG_W-1:0]          step
  );
    logic signed [SPEED_W+1:0] stp, up, dn, res;
    stp = $signed({2'b00, {(SPEED_W-CFG_W){1'b0}}, step});
    up  = (SPEED_W+2)'(cur) + stp;
    dn  = (SPEED_W+2)'(cur) - stp;
    res = (SPEED_W+2)'(cur);
    if (cur < tgt) begin
      res = (up > (SPEED_W+2)'(tgt)) ? (SPEED_W+2)'(tgt) : up;
    end else if (cur > tgt) begin
      res = (dn < (SPEED_W+2)'(tgt)) ? (SPEED_W+2)'(tgt) : dn;
    end
    return res[SPEED_W-1:0];
  endfunction

  function automatic logic signed [INTEG_W-1:0] sat32_f(input logic signed [34:0] v);
    logic signed [34:0] hi, lo;
    hi = 35'sh0_7FFF_FFFF;
    lo = -35'sh0_8000_0000;
    if (v > hi) return INTEG_W'(hi);
    if (v < lo) return INTEG_W'(lo);
    return v[INTEG_W-1:0];
  endfunction

  function automatic logic signed [31:0] clamp_f(input logic signed [31:0] v);
    if (v > PWM_HI) return PWM_HI;
    if (v < PWM_LO) return PWM_LO;
    return v;
  endfunction

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [CFG_W-1:0] ramp_step_x_r, ramp_step_w_r;
  logic [CFG_W-1:0] kp_forward_r, kd_forward_r, kp_rotate_r, kd_rotate_r;
  logic [CFG_W-1:0] gyro_gain_r;
  logic [1:0]       feedback_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_x_r   <= RST_RAMP_STEP_X;
      ramp_step_w_r   <= RST_RAMP_STEP_W;
      kp_forward_r    <= RST_KP_FORWARD;
      kd_forward_r    <= RST_KD_FORWARD;
      kp_rotate_r     <= RST_KP_ROTATE;
      kd_rotate_r     <= RST_KD_ROTATE;
      feedback_mode_r <= FB_MODE_GYRO_ENC;
      gyro_gain_r     <= RST_GYRO_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RAMP_STEP_X:   ramp_step_x_r   <= cfg_wdata;
        CFG_RAMP_STEP_W:   ramp_step_w_r   <= cfg_wdata;
        CFG_KP_FORWARD:    kp_forward_r    <= cfg_wdata;
        CFG_KD_FORWARD:    kd_forward_r    <= cfg_wdata;
        CFG_KP_ROTATE:     kp_rotate_r     <= cfg_wdata;
        CFG_KD_ROTATE:     kd_rotate_r     <= cfg_wdata;
        CFG_FEEDBACK_MODE: feedback_mode_r <= cfg_wdata[1:0];
        CFG_GYRO_GAIN:     gyro_gain_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // pipeline flow control: slot k fills whenever it is empty or its
  // occupant moves on, so bubbles collapse under a stalled output
  // ---------------------------------------------------------------
  logic [PIPE_SLOTS:1] vld_r, vld_nxt, rdy;

  always_comb begin
    rdy[PIPE_SLOTS] = !vld_r[PIPE_SLOTS] || out_ch.ready;
    for (int k = PIPE_SLOTS - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[1] = rdy[1] ? in_ch.valid : vld_r[1];
    for (int k = 2; k <= PIPE_SLOTS; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign in_ch.ready = rdy[1];

  // a tick leaves slot k when it is valid and slot k+1 takes it
  logic s1_fire, s3_fire;
  assign s1_fire = vld_r[1] && rdy[2];
  assign s3_fire = vld_r[3] && rdy[4];

  // ---------------------------------------------------------------
  // loop state
  // ---------------------------------------------------------------
  logic [COUNT_W-1:0]         prev_left_r, prev_right_r;
  logic signed [SPEED_W-1:0]  speed_fwd_r, speed_rot_r;
  logic signed [INTEG_W-1:0]  integ_fwd_r, integ_rot_r;
  logic signed [SPEED_W-1:0]  speed_fwd_nxt, speed_rot_nxt;
  logic signed [INTEG_W-1:0]  integ_fwd_nxt, integ_rot_nxt;

  // ---------------------------------------------------------------
  // slot 1: input register; encoder differences, gyro product, sensor divide
  // ---------------------------------------------------------------
  logic [COUNT_W-1:0]         s1_left_r, s1_right_r;
  logic signed [SAMPLE_W-1:0] s1_gyro_r, s1_side_r;
  logic                       s1_use_side_r;
  logic signed [SPEED_W-1:0]  s1_tgt_fwd_r, s1_tgt_rot_r;

  logic signed [COUNT_W-1:0]  dl, dr;
  logic signed [COUNT_W:0]    sum_x, dif_w, adj_x, adj_w;
  logic signed [COUNT_W-1:0]  fb_x, fb_w;
  logic signed [32:0]         gyro_prod;
  logic [SAMPLE_W-1:0]        side_mag;
  logic [48:0]                side_prod;

  assign dl    = $signed(s1_left_r - prev_left_r);
  assign dr    = $signed(s1_right_r - prev_right_r);
  // halve with truncation toward zero
  assign sum_x = (COUNT_W+1)'(dl) + (COUNT_W+1)'(dr);
  assign dif_w = (COUNT_W+1)'(dr) - (COUNT_W+1)'(dl);
  assign adj_x = sum_x + (sum_x[COUNT_W] ? 17'sd1 : 17'sd0);
  assign adj_w = dif_w + (dif_w[COUNT_W] ? 17'sd1 : 17'sd0);
  assign fb_x  = adj_x[COUNT_W:1];
  assign fb_w  = adj_w[COUNT_W:1];

  assign gyro_prod = 33'(s1_gyro_r) * $signed({17'd0, gyro_gain_r});

  // divide the magnitude, restore the sign later: truncation toward zero
  assign side_mag  = s1_side_r[SAMPLE_W-1] ? SAMPLE_W'(-s1_side_r) : SAMPLE_W'(s1_side_r);
  assign side_prod = 49'(side_mag) * 49'(SIDE_RECIP);

  // ---------------------------------------------------------------
  // slot 2: rotational feedback assembly
  // ---------------------------------------------------------------
  logic signed [COUNT_W-1:0]  s2_fb_x_r, s2_fb_w_r;
  logic signed [32:0]         s2_gyro_prod_r;
  logic [SAMPLE_W-1:0]        s2_side_q_r;
  logic                       s2_side_neg_r, s2_use_side_r;
  logic signed [SPEED_W-1:0]  s2_tgt_fwd_r, s2_tgt_rot_r;

  logic signed [33:0] gyro_neg, gyro_adj;
  logic signed [29:0] gyro_fb;
  logic signed [27:0] enc_fb;
  logic signed [16:0] side_q_s;
  logic signed [28:0] sens_fb;
  logic signed [31:0] rot_fb;

  // gyro term = (-rate * gain) / 16, truncated toward zero
  assign gyro_neg = -34'(s2_gyro_prod_r);
  assign gyro_adj = gyro_neg + (gyro_neg[33] ? 34'sd15 : 34'sd0);
  assign gyro_fb  = gyro_adj[33:4];
  assign enc_fb   = {s2_fb_w_r, 12'd0};
  assign side_q_s = s2_side_neg_r ? -$signed({1'b0, s2_side_q_r}) : $signed({1'b0, s2_side_q_r});
  assign sens_fb  = {side_q_s, 12'd0};

  always_comb begin
    case (feedback_mode_r)
      FB_MODE_GYRO: rot_fb = 32'(gyro_fb);
      FB_MODE_ENC:  rot_fb = 32'(enc_fb);
      default:      rot_fb = 32'(gyro_fb) + 32'(enc_fb);
    endcase
    if (s2_use_side_r) begin
      rot_fb = rot_fb - 32'(sens_fb);
    end
  end

  // ---------------------------------------------------------------
  // slot 3: speed ramps and integrators (loop state lives here)
  // ---------------------------------------------------------------
  logic signed [COUNT_W-1:0]  s3_fb_x_r;
  logic signed [31:0]         s3_rot_fb_r;
  logic signed [SPEED_W-1:0]  s3_tgt_fwd_r, s3_tgt_rot_r;

  logic signed [27:0]         fwd_fb;
  logic signed [DELTA_W-1:0]  delta_fwd, delta_rot;

  assign fwd_fb        = {s3_fb_x_r, 12'd0};
  assign speed_fwd_nxt = ramp_f(speed_fwd_r, s3_tgt_fwd_r, ramp_step_x_r);
  assign speed_rot_nxt = ramp_f(speed_rot_r, s3_tgt_rot_r, ramp_step_w_r);
  assign integ_fwd_nxt = sat32_f(35'(integ_fwd_r) + 35'(speed_fwd_nxt) - 35'(fwd_fb));
  assign integ_rot_nxt = sat32_f(35'(integ_rot_r) + 35'(speed_rot_nxt) - 35'(s3_rot_fb_r));
  // the integrator register still holds last tick's value here
  assign delta_fwd     = DELTA_W'(integ_fwd_nxt) - DELTA_W'(integ_fwd_r);
  assign delta_rot     = DELTA_W'(integ_rot_nxt) - DELTA_W'(integ_rot_r);

  // ---------------------------------------------------------------
  // slots 4-5: pd law per axis (products, then scale by 2^-20)
  // ---------------------------------------------------------------
  logic signed [INTEG_W-1:0]  s4_integ_fwd_r, s4_integ_rot_r;
  logic signed [DELTA_W-1:0]  s4_delta_fwd_r, s4_delta_rot_r;
  logic signed [COUNT_W-1:0]  s4_fb_x_r, s5_fb_x_r, s6_fb_x_r;
  logic signed [SPEED_W-1:0]  s4_speed_r, s5_speed_r, s6_speed_r;
  logic signed [DRIVE_W-1:0]  drive_x, drive_w;
  pd_en_t                     pd_en;

  assign pd_en.prod_ld  = rdy[5];
  assign pd_en.drive_ld = rdy[6];

  ddsp_pd_law u_pd_fwd (
    .clk   (clk),
    .en    (pd_en),
    .kp    (kp_forward_r),
    .kd    (kd_forward_r),
    .integ (s4_integ_fwd_r),
    .delta (s4_delta_fwd_r),
    .drive (drive_x)
  );

  ddsp_pd_law u_pd_rot (
    .clk   (clk),
    .en    (pd_en),
    .kp    (kp_rotate_r),
    .kd    (kd_rotate_r),
    .integ (s4_integ_rot_r),
    .delta (s4_delta_rot_r),
    .drive (drive_w)
  );

  // ---------------------------------------------------------------
  // slot 6: mix, clamp, direction split
  // ---------------------------------------------------------------
  logic signed [31:0] left_cmd, right_cmd, left_cl, right_inv;
  logic signed [31:0] left_mag, right_mag;
  logic [PWM_W-1:0]   lf, lr, rf, rr;

  assign left_cmd  = 32'(drive_x) - 32'(drive_w);
  assign right_cmd = 32'(drive_x) + 32'(drive_w);
  assign left_cl   = clamp_f(left_cmd);
  assign right_inv = -clamp_f(right_cmd);
  assign left_mag  = -left_cl;
  assign right_mag = -right_inv;
  // non-negative drives channel a, negative drives channel b
  assign lf = left_cl[31]   ? '0 : left_cl[PWM_W-1:0];
  assign lr = left_cl[31]   ? left_mag[PWM_W-1:0] : '0;
  assign rf = right_inv[31] ? '0 : right_inv[PWM_W-1:0];
  assign rr = right_inv[31] ? right_mag[PWM_W-1:0] : '0;

  // slot 7: output register
  logic [PWM_W-1:0]          o_lf_r, o_lr_r, o_rf_r, o_rr_r;
  logic signed [COUNT_W-1:0] o_fwd_chg_r;
  logic signed [SPEED_W-1:0] o_speed_r;

  // ---------------------------------------------------------------
  // control and state registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      speed_fwd_r  <= '0;
      speed_rot_r  <= '0;
      integ_fwd_r  <= '0;
      integ_rot_r  <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (s1_fire) begin
        prev_left_r  <= s1_left_r;
        prev_right_r <= s1_right_r;
      end
      if (s3_fire) begin
        speed_fwd_r <= speed_fwd_nxt;
        speed_rot_r <= speed_rot_nxt;
        integ_fwd_r <= integ_fwd_nxt;
        integ_rot_r <= integ_rot_nxt;
      end
    end
  end

  // ---------------------------------------------------------------
  // payload registers, loaded whenever their slot can take a beat
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_left_r     <= in_ch.left_count;
      s1_right_r    <= in_ch.right_count;
      s1_gyro_r     <= in_ch.gyro_rate;
      s1_side_r     <= in_ch.side_error;
      s1_use_side_r <= in_ch.use_side_error;
      s1_tgt_fwd_r  <= in_ch.target_forward;
      s1_tgt_rot_r  <= in_ch.target_rotate;
    end
    if (rdy[2]) begin
      s2_fb_x_r      <= fb_x;
      s2_fb_w_r      <= fb_w;
      s2_gyro_prod_r <= gyro_prod;
      s2_side_q_r    <= side_prod[47:32];
      s2_side_neg_r  <= s1_side_r[SAMPLE_W-1];
      s2_use_side_r  <= s1_use_side_r;
      s2_tgt_fwd_r   <= s1_tgt_fwd_r;
      s2_tgt_rot_r   <= s1_tgt_rot_r;
    end
    if (rdy[3]) begin
      s3_fb_x_r    <= s2_fb_x_r;
      s3_rot_fb_r  <= rot_fb;
      s3_tgt_fwd_r <= s2_tgt_fwd_r;
      s3_tgt_rot_r <= s2_tgt_rot_r;
    end
    if (rdy[4]) begin
      s4_integ_fwd_r <= integ_fwd_nxt;
      s4_integ_rot_r <= integ_rot_nxt;
      s4_delta_fwd_r <= delta_fwd;
      s4_delta_rot_r <= delta_rot;
      s4_fb_x_r      <= s3_fb_x_r;
      s4_speed_r     <= speed_fwd_nxt;
    end
    if (rdy[5]) begin
      s5_fb_x_r  <= s4_fb_x_r;
      s5_speed_r <= s4_speed_r;
    end
    if (rdy[6]) begin
      s6_fb_x_r  <= s5_fb_x_r;
      s6_speed_r <= s5_speed_r;
    end
    if (rdy[7]) begin
      o_lf_r      <= lf;
      o_lr_r      <= lr;
      o_rf_r      <= rf;
      o_rr_r      <= rr;
      o_fwd_chg_r <= s6_fb_x_r;
      o_speed_r   <= s6_speed_r;
    end
  end

  assign out_ch.valid             = vld_r[PIPE_SLOTS];
  assign out_ch.left_pwm_fwd      = o_lf_r;
  assign out_ch.left_pwm_rev      = o_lr_r;
  assign out_ch.right_pwm_fwd     = o_rf_r;
  assign out_ch.right_pwm_rev     = o_rr_r;
  assign out_ch.forward_change    = o_fwd_chg_r;
  assign out_ch.speed_forward_now = o_speed_r;

endmodule

FILE: rtl/core/ddsp_pd_law.sv
module ddsp_pd_law import ddsp_pkg::*; (
  input  logic                      clk,
  input  pd_en_t                    en,
  input  logic [CFG_W-1:0]          kp,
  input  logic [CFG_W-1:0]          kd,
  input  logic signed [INTEG_W-1:0] integ,
  input  logic signed [DELTA_W-1:0] delta,
  output logic signed [DRIVE_W-1:0] drive
);

  localparam int unsigned PROD_W = 50;
  localparam int unsigned SUM_W  = 51;
  localparam int unsigned SHIFT  = 20;

  logic signed [PROD_W-1:0] p_term, d_term;
  logic signed [PROD_W-1:0] p_term_r, d_term_r;
  logic signed [SUM_W-1:0]  pd_sum, pd_adj;
  logic signed [DRIVE_W-1:0] drive_r;

  // gains are unsigned, so zero-extend before the signed multiply
  assign p_term = PROD_W'($signed({1'b0, kp})) * PROD_W'(integ);
  assign d_term = PROD_W'($signed({1'b0, kd})) * PROD_W'(delta);

  // divide by 2^20 truncating toward zero
  assign pd_sum = SUM_W'(p_term_r) + SUM_W'(d_term_r);
  assign pd_adj = pd_sum + (pd_sum[SUM_W-1] ? SUM_W'((64'd1 << SHIFT) - 64'd1) : '0);

  always_ff @(posedge clk) begin
    if (en.prod_ld) begin
      p_term_r <= p_term;
      d_term_r <= d_term;
    end
    if (en.drive_ld) begin
      drive_r <= pd_adj[SUM_W-1:SHIFT];
    end
  end

  assign drive = drive_r;

endmodule

FILE: rtl/core/ddsp_checker.sv
module ddsp_checker import ddsp_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [PWM_W-1:0]          out_left_pwm_fwd,
  input logic [PWM_W-1:0]          out_left_pwm_rev,
  input logic [PWM_W-1:0]          out_right_pwm_fwd,
  input logic [PWM_W-1:0]          out_right_pwm_rev,
  input logic signed [COUNT_W-1:0] out_forward_change,
  input logic signed [SPEED_W-1:0] out_speed_forward_now
);

  localparam int unsigned CNT_W = $clog2(PIPE_SLOTS + 1) + 1;

  logic [CNT_W-1:0] pending_r;
  logic             in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // ticks accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + CNT_W'(in_beat) - CNT_W'(out_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_left_pwm_fwd) && $stable(out_left_pwm_rev)
      && $stable(out_right_pwm_fwd) && $stable(out_right_pwm_rev)
      && $stable(out_forward_change) && $stable(out_speed_forward_now))
    else $error("result payload changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0 && pending_r <= CNT_W'(PIPE_SLOTS))
    else $error("result without a matching tick or too many ticks in flight");

  a_drained_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

endmodule

bind diff_drive_speed_pd_loop_unit ddsp_checker u_ddsp_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_ch.valid),
  .in_ready              (in_ch.ready),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .out_left_pwm_fwd      (out_ch.left_pwm_fwd),
  .out_left_pwm_rev      (out_ch.left_pwm_rev),
  .out_right_pwm_fwd     (out_ch.right_pwm_fwd),
  .out_right_pwm_rev     (out_ch.right_pwm_rev),
  .out_forward_change    (out_ch.forward_change),
  .out_speed_forward_now (out_ch.speed_forward_now)
);
